// ----- hdl/ffba_pkg.sv -----
// -----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and controller/datapath types of the first-fit
// block allocator.
// -----------------------------------------------------------------------------
package ffba_pkg;

   localparam int unsigned MAX_BLOCKS  = 256;
   localparam int unsigned META_BYTES  = 32;
   localparam int unsigned MAX_REQUEST = 100000000;

   localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned SIZE_W = 27;
   localparam int unsigned CNTR_W = 16;
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned PROD_W = SIZE_W + CNTR_W;
   localparam int unsigned BYTE_W = 35;
   localparam int unsigned META_W = 14;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned ENTRY_W = 1 + SIZE_W + ADDR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 8'd1;

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_ZALLOC = 2'd1,
      ACT_FREE   = 2'd2,
      ACT_RESIZE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_CHECK,
      S_LOOKUP,
      S_LKDONE,
      S_SEARCH,
      S_SRDONE,
      S_RELOLD,
      S_RESP
   } state_type;

   typedef enum logic {
      MODE_LOOKUP = 1'b0,
      MODE_SEARCH = 1'b1
   } scan_mode_type;

   typedef struct packed {
      logic          latch;
      logic          mul;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          scan_en;
      logic          keep;
      logic          take_hit;
      logic          append;
      logic          rel_old;
      logic          copy;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       size_bad;
      logic       addr_zero;
      logic       scan_done;
      logic       old_found;
      logic       old_fits;
      logic       hit;
      logic       append_ok;
   } status_type;

endpackage

// ----- hdl/ffba_req_if.sv -----
// -----------------------------------------------------------------------------
// ffba_req_if
// Request channel: action, sizes and address with valid/ready.
// -----------------------------------------------------------------------------
interface ffba_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      action;
   logic [ffba_pkg::SIZE_W-1:0]     request_size;
   logic [ffba_pkg::CNTR_W-1:0]     item_count;
   logic [ffba_pkg::ADDR_W-1:0]     address;

   modport source (output valid, action, request_size, item_count, address, input ready);
   modport sink   (input valid, action, request_size, item_count, address, output ready);
endinterface

// ----- hdl/ffba_rsp_if.sv -----
// -----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: result address, fill/copy commands and heap statistics.
// -----------------------------------------------------------------------------
interface ffba_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ffba_pkg::ADDR_W-1:0]     result_address;
   logic                            ok;
   logic                            zero_fill;
   logic                            copy_needed;
   logic [ffba_pkg::ADDR_W-1:0]     copy_source;
   logic [ffba_pkg::SIZE_W-1:0]     copy_bytes;
   logic [ffba_pkg::CNT_W-1:0]      free_block_count;
   logic [ffba_pkg::BYTE_W-1:0]     free_byte_total;
   logic [ffba_pkg::CNT_W-1:0]      block_count_out;
   logic [ffba_pkg::BYTE_W-1:0]     byte_total;
   logic [ffba_pkg::META_W-1:0]     meta_byte_total;

   modport source (output valid, result_address, ok, zero_fill, copy_needed, copy_source,
                   copy_bytes, free_block_count, free_byte_total, block_count_out,
                   byte_total, meta_byte_total, input ready);
   modport sink   (input valid, result_address, ok, zero_fill, copy_needed, copy_source,
                   copy_bytes, free_block_count, free_byte_total, block_count_out,
                   byte_total, meta_byte_total, output ready);
endinterface

// ----- hdl/ffba_csr_if.sv -----
// -----------------------------------------------------------------------------
// ffba_csr_if
// Register write channel: index and data with valid/ready.
// -----------------------------------------------------------------------------
interface ffba_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ffba_pkg::CSR_IDX_W-1:0]     index;
   logic [ffba_pkg::ADDR_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/first_fit_block_allocator.sv -----
// -----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block manager without splitting, one word at a time.
// -----------------------------------------------------------------------------
// One request word is handled at a time. Allocate, zeroed allocate and release
// make one table scan and resize makes up to two; a bad size or a zero release
// address skips the scans. The response word is offered once the scans and the
// table updates are done. The address lookup and the first-fit search both walk
// the block table memory one entry per cycle.
// Register writes are taken at any time and must only be issued while idle.
module first_fit_block_allocator (
   input  logic        clock,
   input  logic        reset,
   ffba_req_if.sink    req_ch,
   ffba_rsp_if.source  rsp_ch,
   ffba_csr_if.sink    csr_ch
);

   ffba_pkg::cmd_type    cmd;
   ffba_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   ffba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffba_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_action        (req_ch.action),
      .in_size          (req_ch.request_size),
      .in_count         (req_ch.item_count),
      .in_address       (req_ch.address),
      .csr_we           (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .result_address   (rsp_ch.result_address),
      .ok               (rsp_ch.ok),
      .zero_fill        (rsp_ch.zero_fill),
      .copy_needed      (rsp_ch.copy_needed),
      .copy_source      (rsp_ch.copy_source),
      .copy_bytes       (rsp_ch.copy_bytes),
      .free_block_count (rsp_ch.free_block_count),
      .free_byte_total  (rsp_ch.free_byte_total),
      .block_count_out  (rsp_ch.block_count_out),
      .byte_total       (rsp_ch.byte_total),
      .meta_byte_total  (rsp_ch.meta_byte_total)
   );

endmodule

// ----- hdl/ffba_datapath.sv -----
// -----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, scan engine, heap counters and result words.
// -----------------------------------------------------------------------------
module ffba_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ffba_pkg::cmd_type                cmd,
   output ffba_pkg::status_type             status,
   input  logic [1:0]                       in_action,
   input  logic [ffba_pkg::SIZE_W-1:0]      in_size,
   input  logic [ffba_pkg::CNTR_W-1:0]      in_count,
   input  logic [ffba_pkg::ADDR_W-1:0]      in_address,
   input  logic                             csr_we,
   input  logic [ffba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ffba_pkg::ADDR_W-1:0]      csr_data,
   output logic [ffba_pkg::ADDR_W-1:0]      result_address,
   output logic                             ok,
   output logic                             zero_fill,
   output logic                             copy_needed,
   output logic [ffba_pkg::ADDR_W-1:0]      copy_source,
   output logic [ffba_pkg::SIZE_W-1:0]      copy_bytes,
   output logic [ffba_pkg::CNT_W-1:0]       free_block_count,
   output logic [ffba_pkg::BYTE_W-1:0]      free_byte_total,
   output logic [ffba_pkg::CNT_W-1:0]       block_count_out,
   output logic [ffba_pkg::BYTE_W-1:0]      byte_total,
   output logic [ffba_pkg::META_W-1:0]      meta_byte_total
);

   localparam logic [ffba_pkg::ADDR_W-1:0] META_A = ffba_pkg::ADDR_W'(ffba_pkg::META_BYTES);

   logic [ffba_pkg::ENTRY_W-1:0] block_mem [ffba_pkg::MAX_BLOCKS];

   ffba_pkg::action_type            act_ff, act_in;
   logic [ffba_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [ffba_pkg::CNTR_W-1:0]     count_ff, count_in;
   logic [ffba_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [ffba_pkg::PROD_W-1:0]     eff_ff, eff_in;
   logic [ffba_pkg::ADDR_W-1:0]     base_ff, base_in, limit_ff, limit_in;
   logic [ffba_pkg::CNT_W-1:0]      used_ff, used_in, fblk_ff, fblk_in;
   logic [ffba_pkg::ADDR_W-1:0]     top_ff, top_in;
   logic [ffba_pkg::BYTE_W-1:0]     fbytes_ff, fbytes_in, tbytes_ff, tbytes_in;
   logic [ffba_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            pend_ff, pend_in;
   logic [ffba_pkg::IDX_W-1:0]      didx_ff, didx_in;
   logic [ffba_pkg::ENTRY_W-1:0]    rdata_ff;
   ffba_pkg::scan_mode_type         mode_ff, mode_in;
   logic                            ofound_ff, ofound_in, ofree_ff, ofree_in;
   logic [ffba_pkg::IDX_W-1:0]      oidx_ff, oidx_in, hidx_ff, hidx_in;
   logic [ffba_pkg::SIZE_W-1:0]     osize_ff, osize_in, hsize_ff, hsize_in;
   logic [ffba_pkg::ADDR_W-1:0]     ostart_ff, ostart_in, hstart_ff, hstart_in;
   logic                            hit_ff, hit_in;
   logic [ffba_pkg::ADDR_W-1:0]     res_ff, res_in, src_ff, src_in;
   logic                            ok_ff, ok_in, zero_ff, zero_in, copy_ff, copy_in;
   logic [ffba_pkg::SIZE_W-1:0]     cbytes_ff, cbytes_in;

   logic                            e_free;
   logic [ffba_pkg::SIZE_W-1:0]     e_size, req;
   logic [ffba_pkg::ADDR_W-1:0]     e_start;
   logic                            match, issue, hitnow;
   logic [ffba_pkg::SIZE_W:0]       need;
   logic [ffba_pkg::ADDR_W:0]       new_top;
   logic                            we;
   logic [ffba_pkg::IDX_W-1:0]      waddr;
   logic [ffba_pkg::ENTRY_W-1:0]    wdata;

   assign e_free  = rdata_ff[ffba_pkg::ENTRY_W-1];
   assign e_size  = rdata_ff[ffba_pkg::ENTRY_W-2:ffba_pkg::ADDR_W];
   assign e_start = rdata_ff[ffba_pkg::ADDR_W-1:0];
   assign req     = eff_ff[ffba_pkg::SIZE_W-1:0];
   assign need    = {1'b0, req} + (ffba_pkg::SIZE_W+1)'(ffba_pkg::META_BYTES);
   assign new_top = {1'b0, top_ff} + (ffba_pkg::ADDR_W+1)'(need);

   assign match  = (mode_ff == ffba_pkg::MODE_SEARCH) ? (e_free && (e_size >= req))
                                                       : ((e_start + META_A) == addr_ff);
   assign issue  = cmd.scan_en && (cnt_ff < used_ff);
   assign hitnow = cmd.scan_en && pend_ff && match;

   always_comb begin
      status.action    = act_ff;
      status.size_bad  = (eff_ff == '0) ||
                         (eff_ff > ffba_pkg::PROD_W'(ffba_pkg::MAX_REQUEST));
      status.addr_zero = (addr_ff == '0);
      status.scan_done = cmd.scan_en && ((pend_ff && match) ||
                                         (!pend_ff && (cnt_ff >= used_ff)));
      status.old_found = ofound_ff;
      status.old_fits  = (osize_ff >= req);
      status.hit       = hit_ff;
      status.append_ok = (need <= (ffba_pkg::SIZE_W+1)'(ffba_pkg::MAX_REQUEST)) &&
                         (used_ff < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) &&
                         (new_top <= {1'b0, limit_ff});
   end

   always_comb begin
      act_in = act_ff; size_in = size_ff; count_in = count_ff; addr_in = addr_ff;
      eff_in = eff_ff; base_in = base_ff; limit_in = limit_ff; used_in = used_ff;
      fblk_in = fblk_ff; top_in = top_ff; fbytes_in = fbytes_ff; tbytes_in = tbytes_ff;
      cnt_in = cnt_ff; pend_in = pend_ff; didx_in = didx_ff; mode_in = mode_ff;
      ofound_in = ofound_ff; ofree_in = ofree_ff; oidx_in = oidx_ff;
      osize_in = osize_ff; ostart_in = ostart_ff;
      hit_in = hit_ff; hidx_in = hidx_ff; hsize_in = hsize_ff; hstart_in = hstart_ff;
      res_in = res_ff; ok_in = ok_ff; zero_in = zero_ff; copy_in = copy_ff;
      src_in = src_ff; cbytes_in = cbytes_ff;
      we = 1'b0; waddr = oidx_ff; wdata = {1'b1, osize_ff, ostart_ff};

      if (csr_we) begin
         case (csr_index)
            ffba_pkg::CSR_HEAP_BASE:  base_in  = csr_data;
            ffba_pkg::CSR_HEAP_LIMIT: limit_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.latch) begin
         act_in = ffba_pkg::action_type'(in_action);
         size_in = in_size; count_in = in_count; addr_in = in_address;
         ofound_in = 1'b0; hit_in = 1'b0;
         res_in = '0; ok_in = 1'b0; zero_in = 1'b0; copy_in = 1'b0;
         src_in = '0; cbytes_in = '0;
      end

      if (cmd.mul) begin
         if (act_ff == ffba_pkg::ACT_ZALLOC) begin
            eff_in = ffba_pkg::PROD_W'(size_ff) * ffba_pkg::PROD_W'(count_ff);
         end else begin
            eff_in = ffba_pkg::PROD_W'(size_ff);
         end
      end

      if (cmd.scan_start) begin
         cnt_in = '0; pend_in = 1'b0; mode_in = cmd.scan_mode;
      end else if (cmd.scan_en) begin
         pend_in = issue;
         if (issue) begin
            cnt_in  = cnt_ff + 1'b1;
            didx_in = cnt_ff[ffba_pkg::IDX_W-1:0];
         end
      end

      if (hitnow) begin
         if (mode_ff == ffba_pkg::MODE_LOOKUP) begin
            ofound_in = 1'b1; oidx_in = didx_ff; ofree_in = e_free;
            osize_in = e_size; ostart_in = e_start;
         end else begin
            hit_in = 1'b1; hidx_in = didx_ff; hsize_in = e_size; hstart_in = e_start;
         end
      end

      if (cmd.keep) begin
         res_in = addr_ff; ok_in = 1'b1;
      end

      if (cmd.take_hit) begin
         we = 1'b1; waddr = hidx_ff; wdata = {1'b0, hsize_ff, hstart_ff};
         fblk_in = fblk_ff - 1'b1;
         fbytes_in = fbytes_ff - ffba_pkg::BYTE_W'(hsize_ff);
         res_in = hstart_ff + META_A; ok_in = 1'b1;
         zero_in = (act_ff == ffba_pkg::ACT_ZALLOC);
      end

      if (cmd.append) begin
         we = 1'b1; waddr = used_ff[ffba_pkg::IDX_W-1:0];
         wdata = {1'b0, req, base_ff + top_ff};
         used_in = used_ff + 1'b1;
         top_in = new_top[ffba_pkg::ADDR_W-1:0];
         tbytes_in = tbytes_ff + ffba_pkg::BYTE_W'(req);
         res_in = base_ff + top_ff + META_A; ok_in = 1'b1;
         zero_in = (act_ff == ffba_pkg::ACT_ZALLOC);
      end

      if (cmd.rel_old && !ofree_ff) begin
         we = 1'b1; waddr = oidx_ff; wdata = {1'b1, osize_ff, ostart_ff};
         ofree_in = 1'b1;
         fblk_in = fblk_ff + 1'b1;
         fbytes_in = fbytes_ff + ffba_pkg::BYTE_W'(osize_ff);
      end

      if (cmd.copy) begin
         copy_in = 1'b1; src_in = ostart_ff + META_A; cbytes_in = osize_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         block_mem[waddr] <= wdata;
      end
      rdata_ff <= block_mem[cnt_ff[ffba_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0; limit_ff <= '1; used_ff <= '0; top_ff <= '0;
         fblk_ff <= '0; fbytes_ff <= '0; tbytes_ff <= '0;
         cnt_ff <= '0; pend_ff <= 1'b0;
      end else begin
         base_ff <= base_in; limit_ff <= limit_in; used_ff <= used_in; top_ff <= top_in;
         fblk_ff <= fblk_in; fbytes_ff <= fbytes_in; tbytes_ff <= tbytes_in;
         cnt_ff <= cnt_in; pend_ff <= pend_in;
      end
      act_ff <= act_in; size_ff <= size_in; count_ff <= count_in; addr_ff <= addr_in;
      eff_ff <= eff_in; didx_ff <= didx_in; mode_ff <= mode_in;
      ofound_ff <= ofound_in; ofree_ff <= ofree_in; oidx_ff <= oidx_in;
      osize_ff <= osize_in; ostart_ff <= ostart_in;
      hit_ff <= hit_in; hidx_ff <= hidx_in; hsize_ff <= hsize_in; hstart_ff <= hstart_in;
      res_ff <= res_in; ok_ff <= ok_in; zero_ff <= zero_in; copy_ff <= copy_in;
      src_ff <= src_in; cbytes_ff <= cbytes_in;
   end

   assign result_address   = res_ff;
   assign ok               = ok_ff;
   assign zero_fill        = zero_ff;
   assign copy_needed      = copy_ff;
   assign copy_source      = src_ff;
   assign copy_bytes       = cbytes_ff;
   assign free_block_count = fblk_ff;
   assign free_byte_total  = fbytes_ff;
   assign block_count_out  = used_ff;
   assign byte_total       = tbytes_ff;
   assign meta_byte_total  = ffba_pkg::META_W'(32'(used_ff) * ffba_pkg::META_BYTES);

endmodule

// ----- hdl/ffba_controller.sv -----
// -----------------------------------------------------------------------------
// ffba_controller
// Sequencer for request decode, table scans, updates and the response word.
// -----------------------------------------------------------------------------
module ffba_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ffba_pkg::status_type  status,
   output ffba_pkg::cmd_type     cmd
);

   ffba_pkg::state_type state_ff, state_in;
   logic                succ;

   assign succ = status.hit || status.append_ok;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffba_pkg::S_IDLE:   if (req_valid) state_in = ffba_pkg::S_PREP;
         ffba_pkg::S_PREP:   state_in = ffba_pkg::S_CHECK;
         ffba_pkg::S_CHECK: begin
            case (status.action)
               ffba_pkg::ACT_FREE:
                  state_in = status.addr_zero ? ffba_pkg::S_RESP : ffba_pkg::S_LOOKUP;
               ffba_pkg::ACT_RESIZE:
                  if (status.size_bad) state_in = ffba_pkg::S_RESP;
                  else if (status.addr_zero) state_in = ffba_pkg::S_SEARCH;
                  else state_in = ffba_pkg::S_LOOKUP;
               default:
                  state_in = status.size_bad ? ffba_pkg::S_RESP : ffba_pkg::S_SEARCH;
            endcase
         end
         ffba_pkg::S_LOOKUP: if (status.scan_done) state_in = ffba_pkg::S_LKDONE;
         ffba_pkg::S_LKDONE: begin
            if (status.action == ffba_pkg::ACT_FREE) state_in = ffba_pkg::S_RESP;
            else if (status.old_found && status.old_fits) state_in = ffba_pkg::S_RESP;
            else state_in = ffba_pkg::S_SEARCH;
         end
         ffba_pkg::S_SEARCH: if (status.scan_done) state_in = ffba_pkg::S_SRDONE;
         ffba_pkg::S_SRDONE: begin
            if (succ && status.action == ffba_pkg::ACT_RESIZE && status.old_found)
               state_in = ffba_pkg::S_RELOLD;
            else state_in = ffba_pkg::S_RESP;
         end
         ffba_pkg::S_RELOLD: state_in = ffba_pkg::S_RESP;
         ffba_pkg::S_RESP:   if (rsp_ready) state_in = ffba_pkg::S_IDLE;
         default:            state_in = ffba_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ffba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ffba_pkg::S_PREP: cmd.mul = 1'b1;
         ffba_pkg::S_CHECK: begin
            cmd.scan_start = 1'b1;
            if (status.action == ffba_pkg::ACT_FREE ||
                (status.action == ffba_pkg::ACT_RESIZE && !status.addr_zero))
               cmd.scan_mode = ffba_pkg::MODE_LOOKUP;
            else cmd.scan_mode = ffba_pkg::MODE_SEARCH;
         end
         ffba_pkg::S_LOOKUP, ffba_pkg::S_SEARCH: cmd.scan_en = 1'b1;
         ffba_pkg::S_LKDONE: begin
            if (status.action == ffba_pkg::ACT_FREE) begin
               cmd.rel_old = status.old_found;
            end else if (status.old_found && status.old_fits) begin
               cmd.keep = 1'b1;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = ffba_pkg::MODE_SEARCH;
            end
         end
         ffba_pkg::S_SRDONE: begin
            cmd.take_hit = status.hit;
            cmd.append   = !status.hit && status.append_ok;
         end
         ffba_pkg::S_RELOLD: begin
            cmd.copy    = 1'b1;
            cmd.rel_old = 1'b1;
         end
         ffba_pkg::S_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sim/ffba_checker.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// ffba_checker
// Watches the request, response and register channels of the first-fit block
// allocator, keeps its own copy of the block table and heap counters, works
// out the response to every accepted request and compares each response word
// field by field with the oldest one waiting.
// -----------------------------------------------------------------------------
module ffba_checker
   import ffba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ffba_req_if         req_ch,
   ffba_rsp_if         rsp_ch,
   ffba_csr_if         csr_ch,
   output int          fail_count,
   output int          awaited,
   output int          table_blocks,
   output logic [31:0] heap_used
);

   typedef struct {
      logic [ADDR_W-1:0] result_address;
      logic              ok;
      logic              zero_fill;
      logic              copy_needed;
      logic [ADDR_W-1:0] copy_source;
      logic [SIZE_W-1:0] copy_bytes;
      logic [CNT_W-1:0]  free_block_count;
      logic [BYTE_W-1:0] free_byte_total;
      logic [CNT_W-1:0]  block_count_out;
      logic [BYTE_W-1:0] byte_total;
      logic [META_W-1:0] meta_byte_total;
   } heap_reply_type;

   heap_reply_type    reply_queue[$];

   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] limit_bytes;
   logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
   logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
   bit                blk_free [MAX_BLOCKS];
   int                used_blocks;
   logic [ADDR_W-1:0] top_bytes;
   int                free_blocks;
   longint unsigned   free_bytes;
   longint unsigned   total_bytes;
   int                printed;

   assign awaited      = reply_queue.size();
   assign table_blocks = used_blocks;
   assign heap_used    = top_bytes;

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      fail_count++;
      if (printed < 30) begin
         printed++;
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   function automatic logic [ADDR_W-1:0] payload(input int i);
      return blk_start[i] + ADDR_W'(META_BYTES);
   endfunction

   function automatic int find_block(input logic [ADDR_W-1:0] a);
      if (a == '0) return -1;
      for (int i = 0; i < used_blocks; i++)
         if (payload(i) == a) return i;
      return -1;
   endfunction

   function automatic bit carve(input longint unsigned sz, output logic [ADDR_W-1:0] a);
      longint unsigned need;
      a = '0;
      if (sz == 0 || sz > MAX_REQUEST) return 0;
      for (int i = 0; i < used_blocks; i++) begin
         if (blk_free[i] && blk_size[i] >= sz) begin
            blk_free[i] = 0;
            free_blocks--;
            free_bytes -= blk_size[i];
            a = payload(i);
            return 1;
         end
      end
      need = sz + META_BYTES;
      if (need > MAX_REQUEST) return 0;
      if (used_blocks >= MAX_BLOCKS) return 0;
      if (longint'(top_bytes) + need > longint'(limit_bytes)) return 0;
      blk_start[used_blocks] = base_addr + top_bytes;
      blk_size[used_blocks]  = SIZE_W'(sz);
      blk_free[used_blocks]  = 0;
      a = payload(used_blocks);
      used_blocks++;
      top_bytes   = top_bytes + ADDR_W'(need);
      total_bytes += sz;
      return 1;
   endfunction

   function automatic void mark_free(input int i);
      if (!blk_free[i]) begin
         blk_free[i] = 1;
         free_blocks++;
         free_bytes += blk_size[i];
      end
   endfunction

   function automatic heap_reply_type predict(input action_type act,
                                              input logic [SIZE_W-1:0] sz,
                                              input logic [CNTR_W-1:0] cnt,
                                              input logic [ADDR_W-1:0] a);
      heap_reply_type r;
      int             k;
      r = '{default: '0};
      case (act)
         ACT_ALLOC: begin
            r.ok = carve(longint'(sz), r.result_address);
         end
         ACT_ZALLOC: begin
            r.ok = carve(longint'(sz) * longint'(cnt), r.result_address);
            r.zero_fill = r.ok;
         end
         ACT_FREE: begin
            k = find_block(a);
            if (k >= 0) mark_free(k);
         end
         default: begin
            if (sz != 0 && sz <= MAX_REQUEST) begin
               k = find_block(a);
               if (k >= 0 && blk_size[k] >= sz) begin
                  r.result_address = payload(k);
                  r.ok = 1;
               end else begin
                  r.ok = carve(longint'(sz), r.result_address);
                  if (r.ok && k >= 0) begin
                     r.copy_needed = 1;
                     r.copy_source = payload(k);
                     r.copy_bytes  = blk_size[k];
                     mark_free(k);
                  end
               end
            end
         end
      endcase
      if (!r.ok) r.result_address = '0;
      r.free_block_count = CNT_W'(free_blocks);
      r.free_byte_total  = BYTE_W'(free_bytes);
      r.block_count_out  = CNT_W'(used_blocks);
      r.byte_total       = BYTE_W'(total_bytes);
      r.meta_byte_total  = META_W'(used_blocks * META_BYTES);
      return r;
   endfunction

   initial begin
      fail_count = 0;
      printed    = 0;
   end

   always @(posedge clock) begin
      heap_reply_type want;
      if (reset) begin
         reply_queue.delete();
         base_addr   <= '0;
         limit_bytes <= '1;
         used_blocks = 0;
         top_bytes   = '0;
         free_blocks = 0;
         free_bytes  = 0;
         total_bytes = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reply_queue.size() == 0) begin
               report("unexpected word", rsp_ch.result_address, 0);
            end else begin
               want = reply_queue.pop_front();
               if (rsp_ch.result_address !== want.result_address)
                  report("result_address", rsp_ch.result_address, want.result_address);
               if (rsp_ch.ok !== want.ok) report("ok", rsp_ch.ok, want.ok);
               if (rsp_ch.zero_fill !== want.zero_fill)
                  report("zero_fill", rsp_ch.zero_fill, want.zero_fill);
               if (rsp_ch.copy_needed !== want.copy_needed)
                  report("copy_needed", rsp_ch.copy_needed, want.copy_needed);
               if (rsp_ch.copy_source !== want.copy_source)
                  report("copy_source", rsp_ch.copy_source, want.copy_source);
               if (rsp_ch.copy_bytes !== want.copy_bytes)
                  report("copy_bytes", rsp_ch.copy_bytes, want.copy_bytes);
               if (rsp_ch.free_block_count !== want.free_block_count)
                  report("free_block_count", rsp_ch.free_block_count, want.free_block_count);
               if (rsp_ch.free_byte_total !== want.free_byte_total)
                  report("free_byte_total", rsp_ch.free_byte_total, want.free_byte_total);
               if (rsp_ch.block_count_out !== want.block_count_out)
                  report("block_count_out", rsp_ch.block_count_out, want.block_count_out);
               if (rsp_ch.byte_total !== want.byte_total)
                  report("byte_total", rsp_ch.byte_total, want.byte_total);
               if (rsp_ch.meta_byte_total !== want.meta_byte_total)
                  report("meta_byte_total", rsp_ch.meta_byte_total, want.meta_byte_total);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_HEAP_BASE) base_addr <= csr_ch.data;
            else if (csr_ch.index == CSR_HEAP_LIMIT) limit_bytes <= csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready)
            reply_queue.push_back(predict(action_type'(req_ch.action), req_ch.request_size,
                                          req_ch.item_count, req_ch.address));
      end
   end

endmodule

// ----- sim/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Drives the first-fit block allocator with a directed set of allocate,
// zeroed allocate, release and resize requests followed by random phases
// under several heap base and limit settings, with random stalls on both
// channels; the checker beside the block predicts and compares every word.
// -----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
   import ffba_pkg::*;

   localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 40;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          awaited;
   int          table_blocks;
   logic [31:0] heap_used;
   bit          calm;
   bit          hold_request;
   int          words_sent;
   int          words_back;
   int          csr_writes;
   logic [ADDR_W-1:0] live_addrs[$];

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();
   ffba_csr_if csr_ch ();

   first_fit_block_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ffba_checker chk (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_ch       (csr_ch),
      .fail_count   (fail_count),
      .awaited      (awaited),
      .table_blocks (table_blocks),
      .heap_used    (heap_used)
   );

   always #5 clock = ~clock;

   initial begin
      #40_000_000;
      $display("first_fit_block_allocator regression: fail");
      $finish;
   end

   // keep a pool of addresses handed out, for release and resize
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_back++;
         if (rsp_ch.ok) begin
            live_addrs.push_back(rsp_ch.result_address);
            if (live_addrs.size() > 64) void'(live_addrs.pop_front());
         end
      end
   end

   // response side: random stalls, one long hold when asked
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            for (n = 0; n < 400; n++) @(posedge clock);
            hold_request = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_word(input action_type act, input logic [SIZE_W-1:0] sz,
                            input logic [CNTR_W-1:0] cnt, input logic [ADDR_W-1:0] a);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.request_size <= sz;
      req_ch.item_count   <= cnt;
      req_ch.address      <= a;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      csr_writes++;
   endtask

   function automatic logic [ADDR_W-1:0] pick_addr();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1 || live_addrs.size() == 0) return $urandom;
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return SIZE_W'($urandom_range(1, 256));
      if (r < 16) return SIZE_W'($urandom_range(1, 4096));
      if (r == 16) return '0;
      if (r == 17) return SIZE_W'($urandom_range(MAX_REQUEST - 64, MAX_REQUEST + 64));
      return SIZE_W'($urandom);
   endfunction

   task automatic random_words(input int n);
      action_type act;
      logic [CNTR_W-1:0] cnt;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: act = ACT_ALLOC;
            4:          act = ACT_ZALLOC;
            5, 6, 7:    act = ACT_FREE;
            default:    act = ACT_RESIZE;
         endcase
         cnt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
         send_word(act, pick_size(), cnt, pick_addr());
      end
   endtask

   task automatic directed_word(input action_type act, input logic [SIZE_W-1:0] sz,
                                input logic [CNTR_W-1:0] cnt, input logic [ADDR_W-1:0] a);
      send_word(act, sz, cnt, a);
      drain();
   endtask

   function automatic logic [ADDR_W-1:0] newest();
      return live_addrs.size() ? live_addrs[$] : '0;
   endfunction

   initial begin
      logic [ADDR_W-1:0] a1;
      logic [ADDR_W-1:0] a2;
      clock        = 1'b0;
      reset        = 1'b1;
      calm         = 0;
      hold_request = 0;
      words_sent   = 0;
      words_back   = 0;
      csr_writes   = 0;
      req_ch.valid        <= 1'b0;
      req_ch.action       <= ACT_ALLOC;
      req_ch.request_size <= '0;
      req_ch.item_count   <= '0;
      req_ch.address      <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_HEAP_BASE;
      csr_ch.data         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bad sizes, edges of the size field, every action
      directed_word(ACT_ALLOC, '0, '0, '0);
      directed_word(ACT_ALLOC, '1, '1, '1);
      directed_word(ACT_ALLOC, SIZE_W'(MAX_REQUEST + 1), '0, '0);
      directed_word(ACT_ALLOC, SIZE_W'(MAX_REQUEST), '0, '0);
      directed_word(ACT_ALLOC, SIZE_W'(MAX_REQUEST - META_BYTES), '0, '0);
      directed_word(ACT_ALLOC, 1, '0, '0);
      a1 = newest();
      directed_word(ACT_ZALLOC, 5, 3, '0);
      directed_word(ACT_ZALLOC, 7, '0, '0);
      directed_word(ACT_ZALLOC, '1, '1, '0);
      directed_word(ACT_FREE, '0, '0, '0);
      directed_word(ACT_FREE, '0, '0, 32'h1234_5677);
      directed_word(ACT_FREE, '0, '0, a1);
      directed_word(ACT_FREE, '0, '0, a1);
      directed_word(ACT_RESIZE, 1, '0, a1);
      directed_word(ACT_RESIZE, 40, '0, a1);
      directed_word(ACT_ALLOC, 1, '0, '0);
      directed_word(ACT_RESIZE, '0, '0, a1);
      directed_word(ACT_RESIZE, 64, '0, '0);
      a2 = newest();
      directed_word(ACT_RESIZE, 500, '0, a2);
      directed_word(ACT_RESIZE, 20, '0, 32'hFFFF_FFFF);

      // wrapping base, limit just above the heap top
      write_reg(CSR_HEAP_BASE, 32'hFFFF_FFF0);
      write_reg(CSR_HEAP_LIMIT, heap_used + 3000);
      directed_word(ACT_ALLOC, 2000, '0, '0);
      directed_word(ACT_ALLOC, 2000, '0, '0);

      write_reg(CSR_HEAP_LIMIT, '1);
      hold_request = 1;
      random_words(250);
      drain();
      random_words(50);

      write_reg(CSR_HEAP_BASE, $urandom);
      write_reg(CSR_HEAP_LIMIT, heap_used + $urandom_range(0, 4000));
      random_words(250);

      write_reg(CSR_HEAP_LIMIT, '0);
      random_words(100);

      write_reg(CSR_HEAP_BASE, '1);
      write_reg(CSR_HEAP_LIMIT, '1);
      random_words(350);
      calm = 1;
      random_words(200);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d request words, %0d response words, %0d register writes",
               words_sent, words_back, csr_writes);
      $display("table ended with %0d blocks, heap top 0x%0h", table_blocks, heap_used);
      if (fail_count == 0 && awaited == 0) begin
         $display("first_fit_block_allocator regression: pass");
      end else begin
         $display("first_fit_block_allocator regression: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/ffba_pkg.sv
hdl/ffba_req_if.sv
hdl/ffba_rsp_if.sv
hdl/ffba_csr_if.sv
hdl/ffba_datapath.sv
hdl/ffba_controller.sv
hdl/first_fit_block_allocator.sv
sim/ffba_checker.sv
sim/first_fit_block_allocator_tb.sv
